>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checkers of the core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/core/rlpc_pkg.sv
// ----------------------------------------------------------------------------
// rlpc_pkg
// Types, constants and controller/datapath links of the preload cache.
// ----------------------------------------------------------------------------
package rlpc_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int REF_W   = 16;
    localparam int TOT_W   = 32 + CNT_W + 1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNAVAIL = 2'd1;
    localparam logic [1:0] ST_CAP     = 2'd2;
    localparam logic [1:0] ST_PREP    = 2'd3;

    localparam logic [7:0] CFG_CAPACITY = 8'd0;
    localparam logic [7:0] CFG_BUDGET   = 8'd1;

    typedef struct packed {
        logic        kind;
        logic [31:0] clip_id;
        logic        already_held;
        logic        resolve_ok;
        logic [31:0] expected_bytes;
        logic        prepare_ok;
        logic [31:0] prepared_bytes;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic        now_held;
        logic        hit;
        logic [4:0]  evicted_count;
        logic [4:0]  entry_count;
        logic [31:0] failure_count;
    } t_out_item;

    typedef struct packed {
        logic       load_item;
        logic       idx_inc;
        logic       lookup_step;
        logic       rel_dec;
        logic       hit_upd;
        logic       set_held;
        logic       set_code;
        logic [1:0] code;
        logic       phase1;
        logic       phase2;
        logic       pick_clr;
        logic       pick_step;
        logic       evict;
        logic       fail_inc;
        logic       insert;
        logic       load_out;
    } t_cmd;

    typedef struct packed {
        logic kind;
        logic held;
        logic resolve_ok;
        logic prepare_ok;
        logic found;
        logic used_zero;
        logic idx_last;
        logic exp_over;
        logic prep_over;
        logic room_needed;
        logic phase2;
        logic pick_found;
        logic full;
        logic out_free;
    } t_sts;

endpackage

>>> rtl/core/refcounted_lru_preload_cache.sv
// ----------------------------------------------------------------------------
// refcounted_lru_preload_cache
// Reference-counted LRU cache of clip entries with byte budget and eviction.
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_ready   i_in_data  (t_in_item)
//   out      output     o_out_valid / i_out_ready o_out_data (t_out_item)
//   cfg      input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// An item is accepted in idle, then a lookup scan compares the N entries in
// use, one lookup compare per cycle, and a decide step picks the outcome; a
// miss adds check steps and an eviction scan before each eviction. The lookup
// and eviction scans share one scan index.
// Reset is synchronous and active low; no clearing pass is needed.
// A stalled result holds in the output register; the next item may be
// accepted meanwhile and waits at its end until the register frees.
// ----------------------------------------------------------------------------
module refcounted_lru_preload_cache (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rlpc_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rlpc_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    import rlpc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    rlpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rlpc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

>>> rtl/core/rlpc_dp.sv
// ----------------------------------------------------------------------------
// rlpc_dp
// Slot storage, counters, scan index, budget compare and result register.
// ----------------------------------------------------------------------------
module rlpc_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rlpc_pkg::t_in_item i_item,
    input  rlpc_pkg::t_cmd    i_cmd,
    output rlpc_pkg::t_sts    o_sts,
    input  logic              i_cfg_valid,
    input  logic [7:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output rlpc_pkg::t_out_item o_out_data
);
    import rlpc_pkg::*;

    logic [31:0]      r_clip  [ENTRIES];
    logic [REF_W-1:0] r_refs  [ENTRIES];
    logic [31:0]      r_bytes [ENTRIES];
    logic [63:0]      r_stamp [ENTRIES];

    t_in_item         r_item;
    logic [IDX_W-1:0] r_idx;
    logic [CNT_W-1:0] r_used;
    logic             r_found;
    logic [IDX_W-1:0] r_at;
    logic [REF_W-1:0] r_at_refs;
    logic             r_pfound;
    logic [IDX_W-1:0] r_pick;
    logic [63:0]      r_pick_stamp;
    logic [31:0]      r_pick_bytes;
    logic             r_phase2;
    logic [1:0]       r_code;
    logic             r_now_held;
    logic             r_hit;
    logic [4:0]       r_evicted;
    logic [TOT_W-1:0] r_total;
    logic [63:0]      r_use_ctr;
    logic [31:0]      r_fails;
    logic [4:0]       r_cap;
    logic [31:0]      r_budget;
    logic             r_out_valid;
    t_out_item        r_out;

    logic [63:0]      n_stamp;
    logic [CNT_W-1:0] cap_eff;
    logic [31:0]      need;
    logic             out_free;

    assign n_stamp  = (r_use_ctr == '1) ? r_use_ctr : r_use_ctr + 64'd1;
    assign cap_eff  = (32'(r_cap) > ENTRIES) ? CNT_W'(ENTRIES) : CNT_W'(r_cap);
    assign need     = r_phase2 ? r_item.prepared_bytes : r_item.expected_bytes;
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_sts.kind        = r_item.kind;
        o_sts.held        = r_item.already_held;
        o_sts.resolve_ok  = r_item.resolve_ok;
        o_sts.prepare_ok  = r_item.prepare_ok;
        o_sts.found       = r_found;
        o_sts.used_zero   = (r_used == '0);
        o_sts.idx_last    = ((CNT_W'(r_idx) + CNT_W'(1)) == r_used);
        o_sts.exp_over    = (r_item.expected_bytes > r_budget);
        o_sts.prep_over   = (r_item.prepared_bytes > r_budget);
        o_sts.room_needed = (!r_phase2 && (r_used >= cap_eff)) ||
                            ((r_total + TOT_W'(need)) > TOT_W'(r_budget));
        o_sts.phase2      = r_phase2;
        o_sts.pick_found  = r_pfound;
        o_sts.full        = (r_used == CNT_W'(ENTRIES));
        o_sts.out_free    = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_item;
        end
        if (i_cmd.lookup_step && !r_found && (r_clip[r_idx] == r_item.clip_id)) begin
            r_at      <= r_idx;
            r_at_refs <= r_refs[r_idx];
        end
        if (i_cmd.pick_step && (r_refs[r_idx] == '0) &&
            (!r_pfound || (r_stamp[r_idx] < r_pick_stamp))) begin
            r_pick       <= r_idx;
            r_pick_stamp <= r_stamp[r_idx];
            r_pick_bytes <= r_bytes[r_idx];
        end
        if (i_cmd.rel_dec && r_found && r_item.already_held && (r_at_refs != '0)) begin
            r_refs[r_at] <= r_at_refs - REF_W'(1);
        end
        if (i_cmd.hit_upd) begin
            if (r_at_refs != '1) begin
                r_refs[r_at] <= r_at_refs + REF_W'(1);
            end
            r_stamp[r_at] <= n_stamp;
        end
        if (i_cmd.evict) begin
            for (int i = 0; i < ENTRIES - 1; i++) begin
                if (i >= int'(r_pick)) begin
                    r_clip[i]  <= r_clip[i + 1];
                    r_refs[i]  <= r_refs[i + 1];
                    r_bytes[i] <= r_bytes[i + 1];
                    r_stamp[i] <= r_stamp[i + 1];
                end
            end
        end
        if (i_cmd.insert) begin
            r_clip[r_used[IDX_W-1:0]]  <= r_item.clip_id;
            r_refs[r_used[IDX_W-1:0]]  <= REF_W'(1);
            r_bytes[r_used[IDX_W-1:0]] <= r_item.prepared_bytes;
            r_stamp[r_used[IDX_W-1:0]] <= n_stamp;
        end
        if (i_cmd.load_out) begin
            r_out.status        <= r_code;
            r_out.now_held      <= r_now_held;
            r_out.hit           <= r_hit;
            r_out.evicted_count <= r_evicted;
            r_out.entry_count   <= 5'(r_used);
            r_out.failure_count <= r_fails;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_used      <= '0;
            r_found     <= 1'b0;
            r_pfound    <= 1'b0;
            r_phase2    <= 1'b0;
            r_code      <= ST_OK;
            r_now_held  <= 1'b0;
            r_hit       <= 1'b0;
            r_evicted   <= '0;
            r_total     <= '0;
            r_use_ctr   <= '0;
            r_fails     <= '0;
            r_cap       <= 5'd16;
            r_budget    <= 32'd16777216;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_CAPACITY: r_cap    <= i_cfg_data[4:0];
                    CFG_BUDGET:   r_budget <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load_item || i_cmd.pick_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (i_cmd.load_item) begin
                r_found    <= 1'b0;
                r_code     <= ST_OK;
                r_now_held <= 1'b0;
                r_hit      <= 1'b0;
                r_evicted  <= '0;
            end
            if (i_cmd.lookup_step && (r_clip[r_idx] == r_item.clip_id)) begin
                r_found <= 1'b1;
            end
            if (i_cmd.pick_clr) begin
                r_pfound <= 1'b0;
            end else if (i_cmd.pick_step && (r_refs[r_idx] == '0)) begin
                r_pfound <= 1'b1;
            end
            if (i_cmd.phase1) begin
                r_phase2 <= 1'b0;
            end else if (i_cmd.phase2) begin
                r_phase2 <= 1'b1;
            end
            if (i_cmd.set_code) begin
                r_code <= i_cmd.code;
            end
            if (i_cmd.set_held || i_cmd.insert) begin
                r_now_held <= 1'b1;
            end
            if (i_cmd.hit_upd) begin
                r_now_held <= 1'b1;
                r_hit      <= 1'b1;
                r_use_ctr  <= n_stamp;
            end
            if (i_cmd.insert) begin
                r_use_ctr <= n_stamp;
                r_used    <= r_used + CNT_W'(1);
                r_total   <= r_total + TOT_W'(r_item.prepared_bytes);
            end
            if (i_cmd.evict) begin
                r_used    <= r_used - CNT_W'(1);
                r_total   <= r_total - TOT_W'(r_pick_bytes);
                r_evicted <= r_evicted + 5'd1;
            end
            if (i_cmd.fail_inc && (r_fails != '1)) begin
                r_fails <= r_fails + 32'd1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> rtl/core/rlpc_ctrl.sv
// ----------------------------------------------------------------------------
// rlpc_ctrl
// Sequencer: lookup scan, hit/release update, eviction loop, insert, result.
// ----------------------------------------------------------------------------
module rlpc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  rlpc_pkg::t_sts i_sts,
    output rlpc_pkg::t_cmd o_cmd
);
    import rlpc_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOOKUP = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_CHECK  = 3'd3;
    localparam logic [2:0] S_SCAN   = 3'd4;
    localparam logic [2:0] S_EVICT  = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                if (i_sts.used_zero) begin
                    n_state = S_DECIDE;
                end else begin
                    o_cmd.lookup_step = 1'b1;
                    if (i_sts.idx_last) begin
                        n_state = S_DECIDE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                    end
                end
            end
            S_DECIDE: begin
                n_state = S_DONE;
                if (i_sts.kind) begin
                    o_cmd.rel_dec = 1'b1;
                end else if (i_sts.held) begin
                    o_cmd.set_held = 1'b1;
                end else if (i_sts.found) begin
                    o_cmd.hit_upd = 1'b1;
                end else if (!i_sts.resolve_ok) begin
                    o_cmd.set_code = 1'b1;
                    o_cmd.code     = ST_UNAVAIL;
                end else if (i_sts.exp_over) begin
                    o_cmd.set_code = 1'b1;
                    o_cmd.code     = ST_CAP;
                end else begin
                    o_cmd.phase1 = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.room_needed) begin
                    o_cmd.pick_clr = 1'b1;
                    n_state = S_SCAN;
                end else if (!i_sts.phase2) begin
                    if (!i_sts.prepare_ok) begin
                        o_cmd.fail_inc = 1'b1;
                        o_cmd.set_code = 1'b1;
                        o_cmd.code     = ST_PREP;
                        n_state = S_DONE;
                    end else if (i_sts.prep_over) begin
                        o_cmd.set_code = 1'b1;
                        o_cmd.code     = ST_CAP;
                        n_state = S_DONE;
                    end else begin
                        o_cmd.phase2 = 1'b1;
                    end
                end else begin
                    if (i_sts.full) begin
                        o_cmd.set_code = 1'b1;
                        o_cmd.code     = ST_CAP;
                    end else begin
                        o_cmd.insert = 1'b1;
                    end
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                if (i_sts.used_zero) begin
                    n_state = S_EVICT;
                end else begin
                    o_cmd.pick_step = 1'b1;
                    if (i_sts.idx_last) begin
                        n_state = S_EVICT;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                    end
                end
            end
            S_EVICT: begin
                if (i_sts.pick_found) begin
                    o_cmd.evict = 1'b1;
                    n_state = S_CHECK;
                end else begin
                    o_cmd.set_code = 1'b1;
                    o_cmd.code     = ST_CAP;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/core/rlpc_checker.sv
// ----------------------------------------------------------------------------
// rlpc_checker
// Port-level checks on results of the preload cache.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rlpc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input rlpc_pkg::t_out_item o_out_data
);
    import rlpc_pkg::*;

    `ASSERT_IMPLY(a_count_range, i_clk, i_rst_n, o_out_valid, o_out_data.entry_count <= 5'd16)
    `ASSERT_IMPLY(a_hit_ok, i_clk, i_rst_n, o_out_valid && o_out_data.hit, (o_out_data.status == ST_OK) && o_out_data.now_held)
    `ASSERT_IMPLY(a_fail_free, i_clk, i_rst_n, o_out_valid && (o_out_data.status != ST_OK), !o_out_data.now_held && !o_out_data.hit)
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))

endmodule

bind refcounted_lru_preload_cache rlpc_checker u_rlpc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the reference-counted LRU preload cache. A short stimulus
// table covers the extremes, both operations and the failure codes, then
// random acquire/release traffic runs under several capacity and budget
// settings. Every result is checked field by field against its table row or
// a behavioral predictor of the cache, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    import rlpc_pkg::*;

    localparam logic KIND_ACQUIRE = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;
    localparam int   SLOTS        = 16;

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item result;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index = CFG_CAPACITY;
    logic [31:0] i_cfg_data = '0;

    refcounted_lru_preload_cache i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // cache image
    logic [31:0] slot_clip_q[SLOTS];
    logic [15:0] slot_refs_q[SLOTS];
    logic [31:0] slot_bytes_q[SLOTS];
    logic [63:0] slot_stamp_q[SLOTS];
    int          entries_used;
    logic [63:0] use_ctr;
    logic [31:0] prep_fails;
    logic [4:0]  capacity_reg = 5'd16;
    logic [31:0] budget_reg = 32'd16777216;

    t_out_item   pending_results[$];
    t_row        rows[$];
    int          errors = 0;
    bit          no_gaps = 0;
    bit          long_hold_req = 0;
    logic [31:0] clip_pool[24];

    function automatic logic [63:0] take_stamp();
        if (use_ctr != '1) use_ctr++;
        return use_ctr;
    endfunction

    function automatic bit evict_lru();
        int pick;
        bit found;
        pick = 0;
        found = 0;
        for (int i = 0; i < entries_used; i++)
            if (slot_refs_q[i] == 0 && (!found || slot_stamp_q[i] < slot_stamp_q[pick])) begin
                pick = i;
                found = 1;
            end
        if (!found) return 0;
        for (int i = pick; i + 1 < entries_used; i++) begin
            slot_clip_q[i]  = slot_clip_q[i + 1];
            slot_refs_q[i]  = slot_refs_q[i + 1];
            slot_bytes_q[i] = slot_bytes_q[i + 1];
            slot_stamp_q[i] = slot_stamp_q[i + 1];
        end
        entries_used--;
        return 1;
    endfunction

    function automatic bit make_room(logic [31:0] need, bit limit_count, inout int evicted);
        int          lim;
        logic [63:0] sum;
        lim = (capacity_reg < SLOTS) ? capacity_reg : SLOTS;
        forever begin
            sum = 0;
            for (int i = 0; i < entries_used; i++) sum += slot_bytes_q[i];
            if (!((limit_count && entries_used >= lim) ||
                  sum > {32'd0, budget_reg} - {32'd0, need})) return 1;
            if (!evict_lru()) return 0;
            evicted++;
        end
    endfunction

    function automatic t_out_item cache_apply(t_in_item it);
        t_out_item r;
        int        at;
        int        evicted;
        bit        found;
        r = '0;
        r.status = ST_OK;
        at = 0;
        evicted = 0;
        found = 0;
        for (int i = 0; i < entries_used; i++)
            if (!found && slot_clip_q[i] == it.clip_id) begin
                at = i;
                found = 1;
            end
        if (it.kind == KIND_RELEASE) begin
            if (it.already_held && found && slot_refs_q[at] > 0) slot_refs_q[at]--;
        end else if (it.already_held) begin
            r.now_held = 1;
        end else if (found) begin
            if (slot_refs_q[at] != '1) slot_refs_q[at]++;
            slot_stamp_q[at] = take_stamp();
            r.now_held = 1;
            r.hit = 1;
        end else if (!it.resolve_ok) begin
            r.status = ST_UNAVAIL;
        end else if (it.expected_bytes > budget_reg ||
                     !make_room(it.expected_bytes, 1, evicted)) begin
            r.status = ST_CAP;
        end else if (!it.prepare_ok) begin
            if (prep_fails != '1) prep_fails++;
            r.status = ST_PREP;
        end else if (it.prepared_bytes > budget_reg ||
                     !make_room(it.prepared_bytes, 0, evicted)) begin
            r.status = ST_CAP;
        end else if (entries_used < SLOTS) begin
            slot_clip_q[entries_used]  = it.clip_id;
            slot_refs_q[entries_used]  = 1;
            slot_bytes_q[entries_used] = it.prepared_bytes;
            slot_stamp_q[entries_used] = take_stamp();
            entries_used++;
            r.now_held = 1;
        end else begin
            r.status = ST_CAP;
        end
        r.evicted_count = evicted[4:0];
        r.entry_count   = entries_used[4:0];
        r.failure_count = prep_fails;
        return r;
    endfunction

    function automatic t_in_item mk_item(logic kind, logic [31:0] clip, logic held,
                                         logic res, logic [31:0] exp_b, logic pok,
                                         logic [31:0] prep_b);
        t_in_item it;
        it.kind = kind;
        it.clip_id = clip;
        it.already_held = held;
        it.resolve_ok = res;
        it.expected_bytes = exp_b;
        it.prepare_ok = pok;
        it.prepared_bytes = prep_b;
        return it;
    endfunction

    function automatic t_out_item mk_result(logic [1:0] st, logic nh, logic h,
                                            logic [4:0] ev, logic [4:0] cnt,
                                            logic [31:0] fc);
        t_out_item r;
        r.status = st;
        r.now_held = nh;
        r.hit = h;
        r.evicted_count = ev;
        r.entry_count = cnt;
        r.failure_count = fc;
        return r;
    endfunction

    function automatic void add_row(t_in_item it, bit typed, t_out_item res);
        t_row row;
        row.item = it;
        row.typed = typed;
        row.result = res;
        rows.insert(rows.size(), row);
    endfunction

    function automatic logic [31:0] rand_bytes();
        int          sel;
        logic [31:0] lim;
        sel = $urandom_range(0, 9);
        lim = (budget_reg > 8) ? budget_reg / 4 : budget_reg;
        if (sel == 0) return $urandom;
        if (sel == 1) return budget_reg;
        return $urandom_range(0, lim);
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        it.kind = ($urandom_range(0, 3) == 0) ? KIND_RELEASE : KIND_ACQUIRE;
        it.clip_id = ($urandom_range(0, 9) == 0) ? $urandom : clip_pool[$urandom_range(0, 23)];
        it.already_held = (it.kind == KIND_RELEASE) ? ($urandom_range(0, 3) != 0)
                                                    : ($urandom_range(0, 9) == 0);
        it.resolve_ok = ($urandom_range(0, 19) != 0);
        it.expected_bytes = rand_bytes();
        it.prepare_ok = ($urandom_range(0, 9) != 0);
        it.prepared_bytes = ($urandom_range(0, 4) == 0) ? rand_bytes()
                                                        : it.expected_bytes;
        return it;
    endfunction

    task automatic send_item(t_in_item it, bit typed, t_out_item typed_result);
        int        gap;
        t_out_item r;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        r = cache_apply(it);
        pending_results.insert(pending_results.size(), typed ? typed_result : r);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_CAPACITY) capacity_reg = value[4:0];
        else budget_reg = value;
        @(posedge i_clk);
    endtask

    // result side: random stall per item, one long hold on request
    initial begin
        int stall;
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 4);
            if (long_hold_req) begin
                long_hold_req = 0;
                stall = 400;
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result item with no expectation: %h", o_out_data);
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (o_out_data.status !== e.status) begin
                    $error("status: expected %0d, actual %0d", e.status, o_out_data.status);
                    errors++;
                end
                if (o_out_data.now_held !== e.now_held) begin
                    $error("now_held: expected %0d, actual %0d", e.now_held,
                           o_out_data.now_held);
                    errors++;
                end
                if (o_out_data.hit !== e.hit) begin
                    $error("hit: expected %0d, actual %0d", e.hit, o_out_data.hit);
                    errors++;
                end
                if (o_out_data.evicted_count !== e.evicted_count) begin
                    $error("evicted_count: expected %0d, actual %0d", e.evicted_count,
                           o_out_data.evicted_count);
                    errors++;
                end
                if (o_out_data.entry_count !== e.entry_count) begin
                    $error("entry_count: expected %0d, actual %0d", e.entry_count,
                           o_out_data.entry_count);
                    errors++;
                end
                if (o_out_data.failure_count !== e.failure_count) begin
                    $error("failure_count: expected %0d, actual %0d", e.failure_count,
                           o_out_data.failure_count);
                    errors++;
                end
            end
        end
    end

    initial begin
        #10ms;
        $display("FAILURE");
        $finish;
    end

    initial begin
        logic [4:0]  caps[6];
        logic [31:0] budgets[6];
        entries_used = 0;
        use_ctr = '0;
        prep_fails = '0;
        foreach (clip_pool[i]) clip_pool[i] = $urandom;
        clip_pool[0] = 32'h0;
        clip_pool[1] = 32'hFFFF_FFFF;
        caps    = '{5'd16, 5'd3, 5'd0, 5'd31, 5'd8, 5'd16};
        budgets = '{32'd16777216, 32'd5000, 32'd5000, 32'hFFFF_FFFF, 32'd0, 32'd2000};

        add_row(mk_item(KIND_RELEASE, 32'd5, 1, 1, 0, 1, 0), 1,
                mk_result(ST_OK, 0, 0, 0, 0, 0));
        add_row(mk_item(KIND_ACQUIRE, 32'd5, 1, 1, 0, 1, 0), 1,
                mk_result(ST_OK, 1, 0, 0, 0, 0));
        add_row(mk_item(KIND_ACQUIRE, 32'd7, 0, 0, 10, 1, 10), 1,
                mk_result(ST_UNAVAIL, 0, 0, 0, 0, 0));
        add_row(mk_item(KIND_ACQUIRE, 32'd7, 0, 1, '1, 1, 10), 1,
                mk_result(ST_CAP, 0, 0, 0, 0, 0));
        add_row(mk_item(KIND_ACQUIRE, 32'd7, 0, 1, 100, 0, 100), 1,
                mk_result(ST_PREP, 0, 0, 0, 0, 1));
        add_row(mk_item(KIND_ACQUIRE, 32'd7, 0, 1, 100, 1, '1), 1,
                mk_result(ST_CAP, 0, 0, 0, 0, 1));
        add_row(mk_item(KIND_ACQUIRE, 32'd0, 0, 1, 0, 1, 0), 1,
                mk_result(ST_OK, 1, 0, 0, 1, 1));
        add_row(mk_item(KIND_ACQUIRE, '1, 0, 1, 32'd16777216, 1, 32'd16777216), 1,
                mk_result(ST_OK, 1, 0, 0, 2, 1));
        add_row(mk_item(KIND_ACQUIRE, 32'd0, 0, 1, 0, 1, 0), 1,
                mk_result(ST_OK, 1, 1, 0, 2, 1));
        add_row(mk_item(KIND_RELEASE, 32'd0, 1, 0, '1, 0, '1), 0, '0);
        add_row(mk_item(KIND_RELEASE, 32'd0, 1, 1, 0, 1, 0), 0, '0);
        add_row(mk_item(KIND_RELEASE, 32'd0, 1, 1, 0, 1, 0), 0, '0);
        add_row(mk_item(KIND_RELEASE, '1, 1, 1, 0, 1, 0), 0, '0);
        add_row(mk_item(KIND_ACQUIRE, 32'd9, 0, 1, 1, 1, 1), 0, '0);
        add_row(mk_item(KIND_RELEASE, 32'd9, 0, 1, 1, 1, 1), 0, '0);
        add_row(mk_item(KIND_ACQUIRE, 32'hA5A5_5A5A, 0, 1, 32'h5A5A, 1, 32'hA5A5), 0, '0);
        add_row(mk_item(KIND_ACQUIRE, 32'd9, 0, 1, 0, 0, 0), 0, '0);
        add_row(mk_item(KIND_ACQUIRE, 32'd11, 0, 1, 32'd16777216, 1, 0), 0, '0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].result);
        drain();

        for (int p = 0; p < 6; p++) begin
            write_reg(CFG_CAPACITY, {27'd0, caps[p]});
            write_reg(CFG_BUDGET, budgets[p]);
            if (p == 1) long_hold_req = 1;
            for (int n = 0; n < 215; n++) begin
                no_gaps = (p % 2 == 1) && (n < 50);
                send_item(rand_item(), 0, '0);
            end
            no_gaps = 0;
            drain();
        end

        repeat (50) @(posedge i_clk);
        if (errors == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

endmodule
